>>> sv/sscf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Secure sensor frame checker package
// Shared widths, status codes and the replay table request bundle.
// ----------------------------------------------------------------------------
package sscf_pkg;

    localparam int BYTE_W        = 8;
    localparam int NODE_W        = 8;
    localparam int SEQ_W         = 32;
    localparam int WORD_W        = 32;
    localparam int TEMP_W        = 16;
    localparam int STATUS_W      = 3;
    localparam int STORE_DEPTH   = 15;
    localparam int STORE_IDX_W   = 4;
    localparam int TABLE_DEPTH   = 256;
    // node id, four sequence bytes, payload, four check bytes
    localparam int HDR_LEN       = 5;
    localparam int CHK_LEN       = 4;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 3'd0,
        STATUS_SHORT    = 3'd1,
        STATUS_MISMATCH = 3'd2,
        STATUS_REPLAY   = 3'd3,
        STATUS_TYPE     = 3'd4
    } status_t;

    // Access request to the replay table
    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [SEQ_W-1:0]  wr_data;
    } replay_req_t;

endpackage
`default_nettype wire

>>> sv/sscf_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Secure sensor frame checker channels
// Valid/ready channels for frame bytes, results and the type code register.
// ----------------------------------------------------------------------------
interface sscf_frame_if;
    logic                        valid;
    logic                        ready;
    logic [sscf_pkg::BYTE_W-1:0] frame_byte;
    logic                        frame_last;

    modport source (output valid, output frame_byte, output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface sscf_result_if;
    logic                                valid;
    logic                                ready;
    logic [sscf_pkg::STATUS_W-1:0]       status;
    logic [sscf_pkg::NODE_W-1:0]         node_out;
    logic [sscf_pkg::SEQ_W-1:0]          seq_out;
    logic signed [sscf_pkg::WORD_W-1:0]  field_x;
    logic signed [sscf_pkg::WORD_W-1:0]  field_y;
    logic signed [sscf_pkg::WORD_W-1:0]  field_z;
    logic signed [sscf_pkg::TEMP_W-1:0]  temperature;

    modport source (output valid, output status, output node_out, output seq_out,
                    output field_x, output field_y, output field_z,
                    output temperature, input ready);
    modport sink   (input valid, input status, input node_out, input seq_out,
                    input field_x, input field_y, input field_z,
                    input temperature, output ready);
endinterface

interface sscf_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sscf_pkg::BYTE_W-1:0] sensor_type_code;

    modport source (output valid, output sensor_type_code, input ready);
    modport sink   (input valid, input sensor_type_code, output ready);
endinterface
`default_nettype wire

>>> sv/sscf_replay_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Replay table
// Highest accepted sequence per node: synchronous memory with a registered read, per-entry
// valid flags so the table reads as zero after reset, write-to-read forwarding.
// ----------------------------------------------------------------------------
module sscf_replay_table (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sscf_pkg::replay_req_t req,
    output logic [sscf_pkg::SEQ_W-1:0] rd_value
);
    import sscf_pkg::*;

    logic [SEQ_W-1:0]       mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [SEQ_W-1:0]       mem_rd_reg;
    logic [SEQ_W-1:0]       fwd_data_reg;
    logic                   rd_vld_reg;
    logic                   fwd_hit_reg;

    // Memory array and its registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_rd_reg   <= mem[req.rd_addr];
            fwd_data_reg <= req.wr_data;
        end
    end

    // Valid flags and read-side control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg  <= valid_reg[req.rd_addr];
                fwd_hit_reg <= req.wr_en && (req.wr_addr == req.rd_addr);
            end
        end
    end

    // Same-edge write wins over the old array content
    assign rd_value = fwd_hit_reg ? fwd_data_reg :
                      (rd_vld_reg ? mem_rd_reg : '0);

endmodule
`default_nettype wire

>>> sv/secure_sensor_frame_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Secure sensor frame checker
// Checks framed sensor messages byte by byte and reports one result per frame.
// ----------------------------------------------------------------------------
// Usage:
//   frame  : one byte per transaction, frame_last on the closing byte.
//   result : one transaction per frame, status plus decoded sensor fields
//            (fields are zero unless status is OK).
//   cfg    : writes the expected sensor type code (reset value 1); write only
//            while no frame is in progress.
// Throughput is one byte per cycle unless the frame channel stalls. The last
// byte taken sets a pending flag; the result register loads once it is free, and
// that load cycle reads the replay table entry fetched when the node id byte came
// in and writes the new sequence back. The node id read of the next frame may hit
// that write in the same cycle and is served by forwarding.
// The result sits in an output register; the frame channel keeps taking bytes
// while it waits and only stalls when a second frame closes before the first
// result is taken.
// Reset clears the position counter and marks every replay entry as unseen,
// so all nodes start from sequence zero with no clearing pass.
// ----------------------------------------------------------------------------
module secure_sensor_frame_checker #(
    parameter int PAYLOAD_LEN = 15
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    sscf_frame_if.sink   frame,
    sscf_result_if.source result,
    sscf_cfg_if.sink     cfg
);
    import sscf_pkg::*;

    localparam int FRAME_LEN = HDR_LEN + PAYLOAD_LEN + CHK_LEN;
    localparam int POS_W     = $clog2(FRAME_LEN + 1);
    localparam int PAY_END   = HDR_LEN + PAYLOAD_LEN;

    // Frame assembly state
    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [WORD_W-1:0] rc_reg,   rc_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [SEQ_W-1:0]  seq_reg,  seq_next;
    logic [WORD_W-1:0] rx_reg,   rx_next;
    logic [BYTE_W-1:0] payload_reg [STORE_DEPTH];
    logic              fin_pending_reg, fin_pending_next;
    logic              fin_short_reg,   fin_short_next;
    logic [BYTE_W-1:0] type_reg;

    // Output register
    logic                     out_valid_reg, out_valid_next;
    status_t                  out_status_reg;
    logic [NODE_W-1:0]        out_node_reg;
    logic [SEQ_W-1:0]         out_seq_reg;
    logic [WORD_W-1:0]        out_x_reg, out_y_reg, out_z_reg;
    logic [TEMP_W-1:0]        out_temp_reg;

    logic              frame_acc;
    logic              in_frame;
    logic [POS_W-1:0]  pos_step;
    logic [POS_W-1:0]  seq_off;
    logic [POS_W-1:0]  chk_off;
    logic [POS_W-1:0]  store_off;
    logic              store_wr;
    logic [WORD_W-1:0] byte_word;
    logic [WORD_W-1:0] mix;
    logic              out_can_load;
    logic              fire;
    logic              mismatch;
    logic              replay;
    status_t           status_calc;
    replay_req_t       tbl_req;
    logic [SEQ_W-1:0]  tbl_value;

    // Handshakes
    assign out_can_load = !out_valid_reg || result.ready;
    assign fire         = fin_pending_reg && out_can_load;
    assign frame.ready  = !(fin_pending_reg && !out_can_load);
    assign frame_acc    = frame.valid && frame.ready;
    assign cfg.ready    = 1'b1;

    // Byte position decode
    assign in_frame  = pos_reg < POS_W'(FRAME_LEN);
    assign pos_step  = in_frame ? pos_reg + POS_W'(1) : pos_reg;
    assign seq_off   = pos_reg - POS_W'(1);
    assign chk_off   = pos_reg - POS_W'(PAY_END);
    assign store_off = pos_reg - POS_W'(HDR_LEN);
    assign store_wr  = frame_acc && (pos_reg >= POS_W'(HDR_LEN))
                       && (pos_reg < POS_W'(HDR_LEN + STORE_DEPTH));
    assign byte_word = WORD_W'(frame.frame_byte);
    assign mix       = rc_reg ^ byte_word;

    // Header, running check and received check accumulation
    // (the running check is kept past the last byte for the closing compare;
    // the node id byte of the next frame reloads it)
    always_comb
    begin
        pos_next         = pos_reg;
        rc_next          = rc_reg;
        node_next        = node_reg;
        seq_next         = seq_reg;
        rx_next          = rx_reg;
        fin_short_next   = fin_short_reg;
        fin_pending_next = fire ? 1'b0 : fin_pending_reg;
        if (frame_acc)
        begin
            if (in_frame)
            begin
                if (pos_reg == '0)
                begin
                    node_next = frame.frame_byte;
                    seq_next  = '0;
                    rx_next   = '0;
                    rc_next   = byte_word;
                end
                else if (pos_reg < POS_W'(HDR_LEN))
                begin
                    seq_next = seq_reg | (byte_word << {seq_off[1:0], 3'b000});
                    rc_next  = rc_reg  ^ (byte_word << {seq_off[1:0], 3'b000});
                end
                else if (pos_reg < POS_W'(PAY_END))
                begin
                    rc_next = {mix[WORD_W-2:0], mix[WORD_W-1]};
                end
                else
                begin
                    rx_next = rx_reg | (byte_word << {chk_off[1:0], 3'b000});
                end
                pos_next = pos_step;
            end
            if (frame.frame_last)
            begin
                pos_next         = '0;
                fin_pending_next = 1'b1;
                fin_short_next   = pos_step < POS_W'(FRAME_LEN);
            end
        end
    end

    // Control and check registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            rc_reg          <= '0;
            node_reg        <= '0;
            seq_reg         <= '0;
            rx_reg          <= '0;
            fin_pending_reg <= 1'b0;
            fin_short_reg   <= 1'b0;
            type_reg        <= BYTE_W'(1);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            rc_reg          <= rc_next;
            node_reg        <= node_next;
            seq_reg         <= seq_next;
            rx_reg          <= rx_next;
            fin_pending_reg <= fin_pending_next;
            fin_short_reg   <= fin_short_next;
            out_valid_reg   <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                type_reg <= cfg.sensor_type_code;
            end
        end
    end

    // Payload store, first bytes of the payload only
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            if (store_wr && (store_off[STORE_IDX_W-1:0] == STORE_IDX_W'(i)))
            begin
                payload_reg[i] <= frame.frame_byte;
            end
        end
    end

    // Replay table: fetch on node id byte, write back on a full, matching frame with a fresh sequence
    assign mismatch = rx_reg != rc_reg;
    assign replay   = seq_reg <= tbl_value;

    always_comb
    begin
        tbl_req.rd_en   = frame_acc && (pos_reg == '0);
        tbl_req.rd_addr = frame.frame_byte;
        tbl_req.wr_en   = fire && !fin_short_reg && !mismatch && !replay;
        tbl_req.wr_addr = node_reg;
        tbl_req.wr_data = seq_reg;
    end

    sscf_replay_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (tbl_req),
        .rd_value (tbl_value)
    );

    // Status in check order
    always_comb
    begin
        if (fin_short_reg)
        begin
            status_calc = STATUS_SHORT;
        end
        else if (mismatch)
        begin
            status_calc = STATUS_MISMATCH;
        end
        else if (replay)
        begin
            status_calc = STATUS_REPLAY;
        end
        else if (payload_reg[0] != type_reg)
        begin
            status_calc = STATUS_TYPE;
        end
        else
        begin
            status_calc = STATUS_OK;
        end
    end

    // Result register
    always_comb
    begin
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_status_reg <= status_calc;
            if (status_calc == STATUS_OK)
            begin
                out_node_reg <= node_reg;
                out_seq_reg  <= seq_reg;
                out_x_reg    <= {payload_reg[4], payload_reg[3],
                                 payload_reg[2], payload_reg[1]};
                out_y_reg    <= {payload_reg[8], payload_reg[7],
                                 payload_reg[6], payload_reg[5]};
                out_z_reg    <= {payload_reg[12], payload_reg[11],
                                 payload_reg[10], payload_reg[9]};
                out_temp_reg <= {payload_reg[14], payload_reg[13]};
            end
            else
            begin
                out_node_reg <= '0;
                out_seq_reg  <= '0;
                out_x_reg    <= '0;
                out_y_reg    <= '0;
                out_z_reg    <= '0;
                out_temp_reg <= '0;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.node_out    = out_node_reg;
    assign result.seq_out     = out_seq_reg;
    assign result.field_x     = out_x_reg;
    assign result.field_y     = out_y_reg;
    assign result.field_z     = out_z_reg;
    assign result.temperature = out_temp_reg;

endmodule
`default_nettype wire

>>> test/secure_sensor_frame_checker_tb.sv
// ----------------------------------------------------------------------------
// Secure sensor frame checker testbench
// Sends frames byte by byte over the frame channel and checks every result
// against an in-bench model (check word, replay table, type code) or a status
// set in the directed table. It starts with those frames, then runs random
// frames under several type code settings with random stalls on both sides.
// ----------------------------------------------------------------------------
module secure_sensor_frame_checker_tb;
    import sscf_pkg::*;

    localparam int PAYLOAD_LEN = 15;
    localparam int FRAME_BYTES = HDR_LEN + PAYLOAD_LEN + CHK_LEN;
    localparam int HOLD_CYCLES = 200;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_DIRECTED  = 13;

    // One expected result transaction
    typedef struct packed {
        status_t            status;
        logic [NODE_W-1:0]  node;
        logic [SEQ_W-1:0]   seq;
        logic [WORD_W-1:0]  fx;
        logic [WORD_W-1:0]  fy;
        logic [WORD_W-1:0]  fz;
        logic [TEMP_W-1:0]  temp;
    } sensor_result_t;

    // One directed frame: payload byte 0 is type_byte, bytes 1..14 are fill
    typedef struct packed {
        logic [7:0]  node;
        logic [31:0] seq;
        logic [7:0]  type_byte;
        logic [7:0]  fill;
        logic [7:0]  len;
        logic        bad_chk;
        logic        typed;
        status_t     want;
    } frame_row_t;

    localparam frame_row_t DIRECTED [N_DIRECTED] = '{
        // sequence zero never beats the cleared table
        '{8'h00, 32'h0000_0000, 8'h01, 8'h00, 8'd24, 1'b0, 1'b1, STATUS_REPLAY},
        '{8'h00, 32'h0000_0001, 8'h01, 8'h00, 8'd24, 1'b0, 1'b0, STATUS_OK},
        '{8'h00, 32'h0000_0001, 8'h01, 8'h11, 8'd24, 1'b0, 1'b1, STATUS_REPLAY},
        // all-ones extremes
        '{8'hFF, 32'hFFFF_FFFF, 8'h01, 8'hFF, 8'd24, 1'b0, 1'b0, STATUS_OK},
        '{8'hFF, 32'h0000_0005, 8'h01, 8'h80, 8'd24, 1'b0, 1'b1, STATUS_REPLAY},
        // short, mismatch, wrong type, then replay since the type check
        // comes after the table update
        '{8'h07, 32'h0000_0003, 8'h01, 8'h7F, 8'd10, 1'b0, 1'b1, STATUS_SHORT},
        '{8'h07, 32'h0000_0003, 8'h01, 8'h7F, 8'd24, 1'b1, 1'b1, STATUS_MISMATCH},
        '{8'h07, 32'h0000_0003, 8'h55, 8'h7F, 8'd24, 1'b0, 1'b1, STATUS_TYPE},
        '{8'h07, 32'h0000_0003, 8'h01, 8'h7F, 8'd24, 1'b0, 1'b1, STATUS_REPLAY},
        // trailing bytes past the frame are ignored
        '{8'h08, 32'h8000_0000, 8'h01, 8'h80, 8'd31, 1'b0, 1'b0, STATUS_OK},
        '{8'h09, 32'h0000_0000, 8'h00, 8'h00, 8'd1,  1'b0, 1'b1, STATUS_SHORT},
        '{8'h09, 32'h0102_0304, 8'h01, 8'hA5, 8'd23, 1'b0, 1'b1, STATUS_SHORT},
        '{8'h09, 32'h7FFF_FFFF, 8'h01, 8'h5A, 8'd24, 1'b0, 1'b0, STATUS_OK}
    };

    logic clk;
    logic rst_n;

    sscf_frame_if  frame_ch ();
    sscf_result_if result_ch ();
    sscf_cfg_if    cfg_ch ();

    secure_sensor_frame_checker #(
        .PAYLOAD_LEN (PAYLOAD_LEN)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Checker model state
    logic [SEQ_W-1:0]  seen_seq [TABLE_DEPTH];
    int                frame_pos;
    logic [WORD_W-1:0] check_acc;
    logic [NODE_W-1:0] cur_node;
    logic [SEQ_W-1:0]  cur_seq;
    logic [WORD_W-1:0] rx_check;
    logic [7:0]        payload_mem [STORE_DEPTH];
    logic [7:0]        type_code;

    sensor_result_t expected_results [$];

    // Bench bookkeeping
    int      error_count  = 0;
    int      bytes_sent   = 0;
    int      results_due  = 0;
    int      cycle_count  = 0;
    bit      no_gaps      = 1'b0;
    bit      hold_sink    = 1'b0;
    int      sink_stall   = 0;
    bit      cur_typed    = 1'b0;
    status_t cur_want     = STATUS_OK;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %h, want %h", what, got, want);
        error_count++;
    endtask

    // Model one accepted byte; a last byte queues its result
    function automatic void predict_frame_byte(input logic [7:0] b, input logic last,
                                               input bit typed, input status_t want);
        sensor_result_t r;
        int idx;
        if (frame_pos < FRAME_BYTES)
        begin
            if (frame_pos == 0)
            begin
                cur_node  = b;
                cur_seq   = '0;
                rx_check  = '0;
                check_acc = {24'b0, b};
            end
            else if (frame_pos <= 4)
            begin
                cur_seq   |= {24'b0, b} << (8 * (frame_pos - 1));
                check_acc ^= {24'b0, b} << (8 * (frame_pos - 1));
            end
            else if (frame_pos < HDR_LEN + PAYLOAD_LEN)
            begin
                idx = frame_pos - HDR_LEN;
                if (idx < STORE_DEPTH)
                    payload_mem[idx] = b;
                check_acc ^= {24'b0, b};
                check_acc  = {check_acc[30:0], check_acc[31]};
            end
            else
            begin
                rx_check |= {24'b0, b} << (8 * ((frame_pos - HDR_LEN - PAYLOAD_LEN) & 3));
            end
            frame_pos++;
        end

        if (!last)
            return;

        r = '0;
        if (frame_pos < FRAME_BYTES)
            r.status = STATUS_SHORT;
        else if (rx_check != check_acc)
            r.status = STATUS_MISMATCH;
        else if (cur_seq <= seen_seq[cur_node])
            r.status = STATUS_REPLAY;
        else
        begin
            seen_seq[cur_node] = cur_seq;
            r.status = (payload_mem[0] != type_code) ? STATUS_TYPE : STATUS_OK;
        end

        if (r.status == STATUS_OK)
        begin
            r.node = cur_node;
            r.seq  = cur_seq;
            r.fx   = {payload_mem[4], payload_mem[3], payload_mem[2], payload_mem[1]};
            r.fy   = {payload_mem[8], payload_mem[7], payload_mem[6], payload_mem[5]};
            r.fz   = {payload_mem[12], payload_mem[11], payload_mem[10], payload_mem[9]};
            r.temp = {payload_mem[14], payload_mem[13]};
        end

        // directed rows with a typed-in status replace the model's result
        if (typed)
        begin
            r = '0;
            r.status = want;
        end
        expected_results.push_back(r);
        results_due++;
        frame_pos = 0;
        check_acc = '0;
    endfunction

    // Monitor: results first, since a result never belongs to the byte of this edge
    always @(posedge clk)
    begin
        sensor_result_t e;
        if (result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result status", 32'(result_ch.status),
                                32'(STATUS_OK));
            end
            else
            begin
                e = expected_results.pop_front();
                if (result_ch.status !== e.status)
                    report_mismatch("status", 32'(result_ch.status), 32'(e.status));
                if (result_ch.node_out !== e.node)
                    report_mismatch("node_out", 32'(result_ch.node_out), 32'(e.node));
                if (result_ch.seq_out !== e.seq)
                    report_mismatch("seq_out", result_ch.seq_out, e.seq);
                if (result_ch.field_x !== e.fx)
                    report_mismatch("field_x", result_ch.field_x, e.fx);
                if (result_ch.field_y !== e.fy)
                    report_mismatch("field_y", result_ch.field_y, e.fy);
                if (result_ch.field_z !== e.fz)
                    report_mismatch("field_z", result_ch.field_z, e.fz);
                if (result_ch.temperature !== e.temp)
                    report_mismatch("temperature", 32'(result_ch.temperature),
                                    32'(e.temp));
            end
        end
        if (frame_ch.valid && frame_ch.ready)
        begin
            bytes_sent++;
            predict_frame_byte(frame_ch.frame_byte, frame_ch.frame_last, cur_typed, cur_want);
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_sink = 1'b0;
            end
            else if (sink_stall > 0)
            begin
                result_ch.ready <= 1'b0;
                sink_stall--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (!no_gaps && $urandom_range(0, 3) == 0)
                    sink_stall = pick_gap();
            end
        end
    end

    // Offer one byte; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                             input status_t want);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_ch.valid      <= 1'b1;
        frame_ch.frame_byte <= b;
        frame_ch.frame_last <= last;
        cur_typed = typed;
        cur_want  = want;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Build a frame with a correct check word (optionally corrupted), send len bytes
    task automatic send_frame(input logic [7:0] node, input logic [31:0] seq,
                              input logic [8*PAYLOAD_LEN-1:0] pl, input int len,
                              input bit bad_chk, input bit typed, input status_t want);
        logic [7:0]  bytes [$];
        logic [31:0] chk;
        int i;
        chk = {24'b0, node} ^ seq;
        bytes.push_back(node);
        for (i = 0; i < 4; i++)
            bytes.push_back(seq[8*i +: 8]);
        for (i = 0; i < PAYLOAD_LEN; i++)
        begin
            bytes.push_back(pl[8*i +: 8]);
            chk ^= {24'b0, pl[8*i +: 8]};
            chk  = {chk[30:0], chk[31]};
        end
        if (bad_chk)
            chk ^= 32'h1 << $urandom_range(0, 31);
        for (i = 0; i < 4; i++)
            bytes.push_back(chk[8*i +: 8]);
        while (bytes.size() < len)
            bytes.push_back(8'($urandom_range(0, 255)));
        for (i = 0; i < len; i++)
            send_byte(bytes[i], i == len - 1, typed && (i == len - 1), want);
    endtask

    // One random frame: mostly well formed, the rest broken or noise
    task automatic random_frame();
        int kind, r, n, i;
        logic [7:0]  node;
        logic [31:0] seq;
        logic [8*PAYLOAD_LEN-1:0] pl;
        kind = $urandom_range(0, 99);
        node = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 75)
            seq = seen_seq[node] + $urandom_range(1, 5000);
        else if (r < 85)
            seq = seen_seq[node];
        else if (r < 92)
            seq = $urandom;
        else
        begin
            // top of the sequence range on a node outside the busy set
            node = 8'($urandom_range(128, 255));
            seq  = 32'hFFFF_FFFF - $urandom_range(0, 3);
        end
        pl = (8*PAYLOAD_LEN)'({$urandom, $urandom, $urandom, $urandom});
        pl[7:0] = ($urandom_range(0, 9) < 8) ? type_code : 8'($urandom_range(0, 255));

        if (kind < 70)
            send_frame(node, seq, pl, FRAME_BYTES, 1'b0, 1'b0, STATUS_OK);
        else if (kind < 80)
            send_frame(node, seq, pl, $urandom_range(1, FRAME_BYTES - 1), 1'b0, 1'b0,
                       STATUS_OK);
        else if (kind < 90)
            send_frame(node, seq, pl, FRAME_BYTES, 1'b1, 1'b0, STATUS_OK);
        else if (kind < 95)
            send_frame(node, seq, pl, $urandom_range(FRAME_BYTES + 1, 40), 1'b0, 1'b0,
                       STATUS_OK);
        else
        begin
            n = $urandom_range(1, 40);
            for (i = 0; i < n; i++)
                send_byte(8'($urandom_range(0, 255)),
                          (i == n - 1) || ($urandom_range(0, 15) == 0), 1'b0, STATUS_OK);
        end
    endtask

    // Stop sending and wait for every queued result, then let the block settle
    task automatic drain();
        frame_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_type_code(input logic [7:0] code);
        cfg_ch.valid            <= 1'b1;
        cfg_ch.sensor_type_code <= code;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        type_code = code;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_phase(input int min_bytes, input int min_results);
        int b0, r0;
        b0 = bytes_sent;
        r0 = results_due;
        while (bytes_sent - b0 < min_bytes || results_due - r0 < min_results)
            random_frame();
    endtask

    // Main sequence
    initial
    begin
        logic [8*PAYLOAD_LEN-1:0] pl;
        int i;
        rst_n                   = 1'b0;
        frame_ch.valid          = 1'b0;
        frame_ch.frame_byte     = '0;
        frame_ch.frame_last     = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.sensor_type_code = '0;

        for (i = 0; i < TABLE_DEPTH; i++)
            seen_seq[i] = '0;
        for (i = 0; i < STORE_DEPTH; i++)
            payload_mem[i] = '0;
        frame_pos = 0;
        check_acc = '0;
        cur_node  = '0;
        cur_seq   = '0;
        rx_check  = '0;
        type_code = 8'd1;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed frames under the reset type code
        for (i = 0; i < N_DIRECTED; i++)
        begin
            pl = (8*PAYLOAD_LEN)'({(PAYLOAD_LEN - 1){DIRECTED[i].fill}});
            pl = {pl[8*PAYLOAD_LEN-9:0], DIRECTED[i].type_byte};
            send_frame(DIRECTED[i].node, DIRECTED[i].seq, pl, DIRECTED[i].len,
                       DIRECTED[i].bad_chk, DIRECTED[i].typed, DIRECTED[i].want);
        end
        drain();

        // Type code zero; starts with a long receiver hold-off under full rate
        write_type_code(8'h00);
        no_gaps   = 1'b1;
        hold_sink = 1'b1;
        for (i = 0; i < 4; i++)
            random_frame();
        no_gaps = 1'b0;
        random_phase(60, 3);
        drain();

        // Type code all ones, no idling on either side
        write_type_code(8'hFF);
        no_gaps = 1'b1;
        random_phase(60, 3);
        no_gaps = 1'b0;
        drain();

        write_type_code(8'($urandom_range(2, 254)));
        random_phase(60, 3);
        drain();

        write_type_code(8'h01);
        random_phase(60, 3);
        drain();

        repeat (8) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            report_mismatch("results outstanding", 32'(expected_results.size()), 32'd0);
        end
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
